/* src/acmp_pkg.sv */
`timescale 1ns / 1ps

package acmp_pkg;

    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    localparam int SLOPE_BITS = 17;
    localparam int RATIO_BITS = 16;
    localparam int MIX_BITS   = 16;
    localparam int COEF_BITS  = 17;
    localparam int WEIGHT_BITS = 17;

    localparam int COMP_SHIFT = 16;
    localparam int EXP_SHIFT  = 12;
    localparam int MIX_SHIFT  = 15;

    localparam int QUEUE_DEPTH = 2;
    localparam int BACK_STAGES = 4;

    localparam logic [WEIGHT_BITS-1:0] MIX_UNITY   = 17'd32768;
    localparam logic [SLOPE_BITS-1:0]  SLOPE_RESET = 17'd16384;
    localparam logic [RATIO_BITS-1:0]  RATIO_RESET = 16'd8192;
    localparam logic [MIX_BITS-1:0]    MIX_RESET   = 16'd32768;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_SLOPE     = 3'd1,
        REG_RATIO     = 3'd2,
        REG_CMIX      = 3'd3,
        REG_EMIX      = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_COMP,
        KIND_EXP
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  neg;
        logic  frame_end;
    } ctl_t;

    typedef struct packed {
        logic [SLOPE_BITS-1:0] compress_slope;
        logic [RATIO_BITS-1:0] expand_ratio;
        logic [MIX_BITS-1:0]   compress_mix;
        logic [MIX_BITS-1:0]   expand_mix;
    } cfg_t;

endpackage

/* src/acmp_front.sv */
`timescale 1ns / 1ps

module acmp_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   frame_end,
    input  logic [SAMPLE_BITS-2:0] threshold,
    input  logic                   q_full,
    output logic                   push,
    output acmp_pkg::ctl_t         ctl,
    output logic [SAMPLE_BITS-1:0] x,
    output logic [SAMPLE_BITS-1:0] diff
);

    logic                   front_valid_reg;
    logic                   front_valid_next;
    acmp_pkg::ctl_t         ctl_reg;
    acmp_pkg::ctl_t         ctl_next;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic [SAMPLE_BITS-1:0] diff_reg;
    logic [SAMPLE_BITS-1:0] diff_next;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] thr_ext;

    always_comb
    begin
        mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        thr_ext = {1'b0, threshold};
        ctl_next.neg       = sample[SAMPLE_BITS-1];
        ctl_next.frame_end = frame_end;
        if (mag == '0 || mag == thr_ext)
        begin
            ctl_next.kind = acmp_pkg::KIND_PASS;
            diff_next     = '0;
        end
        else if (mag > thr_ext)
        begin
            ctl_next.kind = acmp_pkg::KIND_COMP;
            diff_next     = mag - thr_ext;
        end
        else
        begin
            ctl_next.kind = acmp_pkg::KIND_EXP;
            diff_next     = thr_ext - mag;
        end
    end

    assign s_ready = !front_valid_reg || !q_full;
    assign push    = front_valid_reg && !q_full;
    assign front_valid_next = s_ready ? s_valid : front_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    // hold the word until the queue takes it
    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            ctl_reg  <= ctl_next;
            x_reg    <= sample;
            diff_reg <= diff_next;
        end
    end

    assign ctl  = ctl_reg;
    assign x    = x_reg;
    assign diff = diff_reg;

endmodule

/* src/acmp_queue.sv */
`timescale 1ns / 1ps

module acmp_queue #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata     = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == COUNT_BITS'(DEPTH));

endmodule

/* src/acmp_back.sv */
`timescale 1ns / 1ps

module acmp_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   pop,
    input  acmp_pkg::ctl_t         ctl,
    input  logic [SAMPLE_BITS-1:0] x,
    input  logic [SAMPLE_BITS-1:0] diff,
    input  logic [SAMPLE_BITS-2:0] threshold,
    input  acmp_pkg::cfg_t         cfg,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] sample_out,
    output logic                   frame_end_out
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + acmp_pkg::COEF_BITS;
    localparam logic [PW:0] ROUND_C = (PW + 1)'(1) << (acmp_pkg::COMP_SHIFT - 1);
    localparam logic [PW:0] ROUND_E = (PW + 1)'(1) << (acmp_pkg::EXP_SHIFT - 1);
    localparam logic [SB+21:0] ROUND_M = (SB + 22)'(1) << (acmp_pkg::MIX_SHIFT - 1);

    logic advance;

    // stage 1: magnitude product
    logic                          s1_valid_reg;
    acmp_pkg::ctl_t                s1_ctl_reg;
    logic signed [SB-1:0]          s1_x_reg;
    logic [PW-1:0]                 s1_prod_reg;
    logic [PW-1:0]                 s1_prod_next;
    logic [acmp_pkg::COEF_BITS-1:0] coef;

    // stage 2: rounded magnitude, signed wet sample
    logic                          s2_valid_reg;
    logic                          s2_last_reg;
    logic signed [SB-1:0]          s2_x_reg;
    logic signed [SB+2:0]          s2_wet_reg;
    logic signed [SB+2:0]          s2_wet_next;
    logic [acmp_pkg::WEIGHT_BITS-1:0] s2_mix_reg;
    logic [acmp_pkg::WEIGHT_BITS-1:0] s2_mix_next;
    logic [PW:0]                   rnd_c;
    logic [PW:0]                   rnd_e;
    logic [SB+1:0]                 q_c;
    logic [SB+5:0]                 q_e;
    logic [SB+5:0]                 thr_e;
    logic [SB+1:0]                 d_c;
    logic [SB+1:0]                 d_e;
    logic signed [SB+2:0]          p_pos;

    // stage 3: dry and wet products
    logic                          s3_valid_reg;
    logic                          s3_last_reg;
    logic signed [SB+17:0]         s3_dry_reg;
    logic signed [SB+17:0]         s3_dry_next;
    logic signed [SB+20:0]         s3_wet_reg;
    logic signed [SB+20:0]         s3_wet_next;
    logic signed [17:0]            w_dry;
    logic signed [17:0]            w_wet;

    // stage 4: sum, round, saturate
    logic                          out_valid_reg;
    logic                          out_last_reg;
    logic [SB-1:0]                 out_sample_reg;
    logic [SB-1:0]                 out_sample_next;
    logic [SB+21:0]                sum;
    logic [SB+6:0]                 scaled;
    logic                          ovf;

    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && q_valid;

    always_comb
    begin
        case (ctl.kind)
            acmp_pkg::KIND_COMP: coef = cfg.compress_slope;
            default:             coef = {1'b0, cfg.expand_ratio};
        endcase
        s1_prod_next = diff * coef;
    end

    always_comb
    begin
        rnd_c = {1'b0, s1_prod_reg} + ROUND_C;
        rnd_e = {1'b0, s1_prod_reg} + ROUND_E;
        q_c   = rnd_c[PW:acmp_pkg::COMP_SHIFT];
        q_e   = rnd_e[PW:acmp_pkg::EXP_SHIFT];
        thr_e = (SB + 6)'(threshold);
        d_c   = (SB + 2)'(threshold) + q_c;
        d_e   = (q_e >= thr_e) ? '0 : (SB + 2)'(thr_e - q_e);
        case (s1_ctl_reg.kind)
            acmp_pkg::KIND_COMP:
            begin
                p_pos       = $signed({1'b0, d_c});
                s2_mix_next = {1'b0, cfg.compress_mix};
                s2_wet_next = s1_ctl_reg.neg ? -p_pos : p_pos;
            end
            acmp_pkg::KIND_EXP:
            begin
                p_pos       = $signed({1'b0, d_e});
                s2_mix_next = {1'b0, cfg.expand_mix};
                s2_wet_next = s1_ctl_reg.neg ? -p_pos : p_pos;
            end
            default:
            begin
                p_pos       = '0;
                s2_mix_next = acmp_pkg::MIX_UNITY;
                s2_wet_next = {{3{s1_x_reg[SB-1]}}, s1_x_reg};
            end
        endcase
    end

    always_comb
    begin
        w_dry       = $signed({1'b0, acmp_pkg::MIX_UNITY}) - $signed({1'b0, s2_mix_reg});
        w_wet       = $signed({1'b0, s2_mix_reg});
        s3_dry_next = w_dry * s2_x_reg;
        s3_wet_next = w_wet * s2_wet_reg;
    end

    always_comb
    begin
        sum    = {{4{s3_dry_reg[SB+17]}}, s3_dry_reg} + {s3_wet_reg[SB+20], s3_wet_reg} + ROUND_M;
        scaled = sum[SB+21:acmp_pkg::MIX_SHIFT];
        ovf    = !((&scaled[SB+6:SB-1]) || !(|scaled[SB+6:SB-1]));
        if (ovf)
        begin
            out_sample_next = scaled[SB+6] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
        end
        else
        begin
            out_sample_next = scaled[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // stall the whole pipe while the output word waits
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg     <= ctl;
            s1_x_reg       <= x;
            s1_prod_reg    <= s1_prod_next;
            s2_last_reg    <= s1_ctl_reg.frame_end;
            s2_x_reg       <= s1_x_reg;
            s2_wet_reg     <= s2_wet_next;
            s2_mix_reg     <= s2_mix_next;
            s3_last_reg    <= s2_last_reg;
            s3_dry_reg     <= s3_dry_next;
            s3_wet_reg     <= s3_wet_next;
            out_last_reg   <= s3_last_reg;
            out_sample_reg <= out_sample_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = out_sample_reg;
    assign frame_end_out = out_last_reg;

endmodule

/* src/audio_compander_core.sv */
`timescale 1ns / 1ps

// Static compressor/expander with a separate dry/wet mix per branch.
// s_t*: one signed sample per word in s_tdata (bits SAMPLE_BITS-1:0), buffer-end
//   mark on s_tlast. m_t*: one processed, saturated sample per word, same layout,
//   s_tlast copied to m_tlast. Words leave in the order they arrive.
// cfg_*: register writes, index 0 threshold, 1 compress slope, 2 expand ratio,
//   3 compress mix, 4 expand mix; other indexes are dropped. cfg_ready is always
//   high. Write only while no sample is in flight.
// Throughput: one sample per cycle while m_tready is high; the front register, a
//   2-word queue and a 4-stage multiply/mix pipe hold at most 7 samples in flight.
// Stall: a low m_tready with m_tvalid high freezes the back pipe; the queue and
//   front register keep taking words until they fill, then s_tready drops.
// Reset: clears all valid state and loads threshold -20 dB, slope 1/4,
//   expand ratio 2, both mixes fully wet.
module audio_compander_core #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [8*((SAMPLE_BITS+7)/8)-1:0]     s_tdata,   // sample_in
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [8*((SAMPLE_BITS+7)/8)-1:0]     m_tdata,   // sample_out
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [acmp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [acmp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int TDATA_BITS = 8 * ((SAMPLE_BITS + 7) / 8);
    localparam int QW = $bits(acmp_pkg::ctl_t) + 2 * SAMPLE_BITS;
    localparam int CAPACITY = 1 + acmp_pkg::QUEUE_DEPTH + acmp_pkg::BACK_STAGES;
    localparam logic [SAMPLE_BITS-2:0] THRESH_RESET =
        (SAMPLE_BITS - 1)'(((64'd1 << (SAMPLE_BITS - 1)) + 64'd5) / 64'd10);

    logic [SAMPLE_BITS-2:0] thresh_reg;
    logic [SAMPLE_BITS-2:0] thresh_next;
    acmp_pkg::cfg_t         cfg_reg;
    acmp_pkg::cfg_t         cfg_next;

    logic                   push;
    logic                   q_full;
    logic                   q_valid;
    logic                   pop;
    acmp_pkg::ctl_t         f_ctl;
    logic [SAMPLE_BITS-1:0] f_x;
    logic [SAMPLE_BITS-1:0] f_diff;
    logic [QW-1:0]          q_rdata;
    acmp_pkg::ctl_t         b_ctl;
    logic [SAMPLE_BITS-1:0] b_x;
    logic [SAMPLE_BITS-1:0] b_diff;
    logic [SAMPLE_BITS-1:0] sample_out;

    logic [3:0]             inflight_reg;
    logic [3:0]             inflight_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        thresh_next = thresh_reg;
        cfg_next    = cfg_reg;
        if (cfg_valid)
        begin
            unique case (acmp_pkg::reg_idx_t'(cfg_index))
                acmp_pkg::REG_THRESHOLD: thresh_next = cfg_data[SAMPLE_BITS-2:0];
                acmp_pkg::REG_SLOPE:
                    cfg_next.compress_slope = cfg_data[acmp_pkg::SLOPE_BITS-1:0];
                acmp_pkg::REG_RATIO:
                    cfg_next.expand_ratio = cfg_data[acmp_pkg::RATIO_BITS-1:0];
                acmp_pkg::REG_CMIX:
                    cfg_next.compress_mix = cfg_data[acmp_pkg::MIX_BITS-1:0];
                acmp_pkg::REG_EMIX:
                    cfg_next.expand_mix = cfg_data[acmp_pkg::MIX_BITS-1:0];
                default: thresh_next = thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg             <= THRESH_RESET;
            cfg_reg.compress_slope <= acmp_pkg::SLOPE_RESET;
            cfg_reg.expand_ratio   <= acmp_pkg::RATIO_RESET;
            cfg_reg.compress_mix   <= acmp_pkg::MIX_RESET;
            cfg_reg.expand_mix     <= acmp_pkg::MIX_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
            cfg_reg    <= cfg_next;
        end
    end

    acmp_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .sample   (s_tdata[SAMPLE_BITS-1:0]),
        .frame_end(s_tlast),
        .threshold(thresh_reg),
        .q_full   (q_full),
        .push     (push),
        .ctl      (f_ctl),
        .x        (f_x),
        .diff     (f_diff)
    );

    acmp_queue #(
        .WIDTH(QW),
        .DEPTH(acmp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    ({f_ctl, f_x, f_diff}),
        .pop      (pop),
        .rdata    (q_rdata),
        .not_empty(q_valid),
        .full     (q_full)
    );

    assign {b_ctl, b_x, b_diff} = q_rdata;

    acmp_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .pop          (pop),
        .ctl          (b_ctl),
        .x            (b_x),
        .diff         (b_diff),
        .threshold    (thresh_reg),
        .cfg          (cfg_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .sample_out   (sample_out),
        .frame_end_out(m_tlast)
    );

    assign m_tdata = TDATA_BITS'(sample_out);

    always_comb
    begin
        case ({s_tvalid && s_tready, m_tvalid && m_tready})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(CAPACITY))
        else $error("more samples in flight than storage");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != 4'd0)
        else $error("output word with nothing in flight");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !(s_tvalid && s_tready) && inflight_reg == 4'd1)
        |=> !m_tvalid)
        else $error("output word repeated after drain");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> inflight_reg >= 4'(1 + acmp_pkg::QUEUE_DEPTH))
        else $error("input stalled with front and queue not full");

endmodule

/* dv/acmp_checker.sv */
`timescale 1ns / 1ps

module acmp_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [8*((SAMPLE_BITS+7)/8)-1:0]      s_tdata,   // sample_in
    input  logic                                  s_tlast,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [8*((SAMPLE_BITS+7)/8)-1:0]      m_tdata,   // sample_out
    input  logic                                  m_tlast,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [acmp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [acmp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output int                                    fail_count,
    output int                                    pending
);

    localparam longint MAG_TOP = longint'(1) << (SAMPLE_BITS - 1);
    localparam longint THRESHOLD_RESET = (MAG_TOP + 5) / 10;
    localparam longint MIX_ONE = longint'(1) << acmp_pkg::MIX_SHIFT;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   frame_end;
    } out_word_t;

    logic [SAMPLE_BITS-2:0]          threshold;
    logic [acmp_pkg::SLOPE_BITS-1:0] compress_slope;
    logic [acmp_pkg::RATIO_BITS-1:0] expand_ratio;
    logic [acmp_pkg::MIX_BITS-1:0]   compress_mix;
    logic [acmp_pkg::MIX_BITS-1:0]   expand_mix;

    out_word_t companded_samples[$];
    int        samples_in;
    int        samples_out;

    assign pending = samples_in - samples_out;

    function automatic longint blend(input longint dry, input longint wet,
                                     input logic [acmp_pkg::MIX_BITS-1:0] mix);
        longint m;
        longint v;
        m = mix;
        v = ((MIX_ONE - m) * dry + m * wet + (longint'(1) << (acmp_pkg::MIX_SHIFT - 1)))
            >>> acmp_pkg::MIX_SHIFT;
        if (v > MAG_TOP - 1)
            v = MAG_TOP - 1;
        if (v < -MAG_TOP)
            v = -MAG_TOP;
        return v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] compand(input logic [SAMPLE_BITS-1:0] raw);
        longint x;
        longint a;
        longint t;
        longint d;
        longint res;
        x = $signed(raw);
        a = (x < 0) ? -x : x;
        t = threshold;
        if (a == 0 || a == t)
            res = x;
        else if (a > t)
        begin
            d = t + (((a - t) * longint'(compress_slope)
                      + (longint'(1) << (acmp_pkg::COMP_SHIFT - 1))) >>> acmp_pkg::COMP_SHIFT);
            res = blend(x, (x < 0) ? -d : d, compress_mix);
        end
        else
        begin
            d = t - (((t - a) * longint'(expand_ratio)
                      + (longint'(1) << (acmp_pkg::EXP_SHIFT - 1))) >>> acmp_pkg::EXP_SHIFT);
            if (d < 0)
                d = 0;
            res = blend(x, (x < 0) ? -d : d, expand_mix);
        end
        return res[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < MAX_REPORTS)
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t due;
        out_word_t word_in;
        if (!rst_n)
        begin
            threshold      = THRESHOLD_RESET[SAMPLE_BITS-2:0];
            compress_slope = acmp_pkg::SLOPE_RESET;
            expand_ratio   = acmp_pkg::RATIO_RESET;
            compress_mix   = acmp_pkg::MIX_RESET;
            expand_mix     = acmp_pkg::MIX_RESET;
            companded_samples.delete();
            samples_in  = 0;
            samples_out = 0;
            fail_count  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    acmp_pkg::REG_THRESHOLD: threshold = cfg_data[SAMPLE_BITS-2:0];
                    acmp_pkg::REG_SLOPE:
                        compress_slope = cfg_data[acmp_pkg::SLOPE_BITS-1:0];
                    acmp_pkg::REG_RATIO:
                        expand_ratio = cfg_data[acmp_pkg::RATIO_BITS-1:0];
                    acmp_pkg::REG_CMIX:
                        compress_mix = cfg_data[acmp_pkg::MIX_BITS-1:0];
                    acmp_pkg::REG_EMIX:
                        expand_mix = cfg_data[acmp_pkg::MIX_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (companded_samples.size() == 0)
                    report_mismatch("unexpected word, sample_out",
                                    $signed(m_tdata[SAMPLE_BITS-1:0]), 0);
                else
                begin
                    due = companded_samples.pop_front();
                    samples_out++;
                    if (m_tdata[SAMPLE_BITS-1:0] !== due.sample)
                        report_mismatch("sample_out", $signed(m_tdata[SAMPLE_BITS-1:0]),
                                        $signed(due.sample));
                    if (m_tlast !== due.frame_end)
                        report_mismatch("frame_end_out", m_tlast, due.frame_end);
                end
            end
            if (s_tvalid && s_tready)
            begin
                word_in.sample    = compand(s_tdata[SAMPLE_BITS-1:0]);
                word_in.frame_end = s_tlast;
                companded_samples.push_back(word_in);
                samples_in++;
            end
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int SAMPLE_BITS = 24;
    localparam int TDATA_BITS  = 8*((SAMPLE_BITS+7)/8);
    localparam longint MAG_TOP = longint'(1) << (SAMPLE_BITS - 1);
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 220;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [acmp_pkg::CFG_INDEX_BITS-1:0] IDX_SPARE_FIRST = 3'd5;
    localparam logic [acmp_pkg::CFG_INDEX_BITS-1:0] IDX_SPARE_LAST  = 3'd7;

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [TDATA_BITS-1:0]               s_tdata;
    logic                                s_tlast;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [TDATA_BITS-1:0]               m_tdata;
    logic                                m_tlast;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [acmp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [acmp_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    int          fail_count;
    int          pending;
    int          src_idle_pct;
    int          sink_idle_pct;
    int unsigned thr_now;

    audio_compander_core #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    acmp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("audio_compander_core test failed");
        $finish;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99, 0) >= sink_idle_pct);

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        longint mag;
        longint val;
        logic   neg;
        mag = 0;
        case ($urandom_range(9, 0)) inside
            0: mag = 0;
            1: mag = thr_now;
            2: mag = longint'(thr_now) + longint'($urandom_range(64)) - 32;
            3: mag = MAG_TOP;
            [4:5]: mag = $urandom_range(thr_now);
            default: return SAMPLE_BITS'($urandom());
        endcase
        if (mag < 0)
            mag = 0;
        if (mag > MAG_TOP)
            mag = MAG_TOP;
        neg = 1'($urandom_range(1));
        if (!neg && mag == MAG_TOP)
            mag = MAG_TOP - 1;
        val = neg ? -mag : mag;
        return val[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_word(input logic [SAMPLE_BITS-1:0] smp, input logic last);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_BITS'(smp);
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [acmp_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [acmp_pkg::CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == acmp_pkg::REG_THRESHOLD)
            thr_now = val[SAMPLE_BITS-2:0];
    endtask

    task automatic write_all(input logic [acmp_pkg::CFG_DATA_BITS-1:0] thr,
                             input logic [acmp_pkg::CFG_DATA_BITS-1:0] slope,
                             input logic [acmp_pkg::CFG_DATA_BITS-1:0] ratio,
                             input logic [acmp_pkg::CFG_DATA_BITS-1:0] cmix,
                             input logic [acmp_pkg::CFG_DATA_BITS-1:0] emix);
        write_reg(acmp_pkg::REG_THRESHOLD, thr);
        write_reg(acmp_pkg::REG_SLOPE, slope);
        write_reg(acmp_pkg::REG_RATIO, ratio);
        write_reg(acmp_pkg::REG_CMIX, cmix);
        write_reg(acmp_pkg::REG_EMIX, emix);
        write_reg(acmp_pkg::CFG_INDEX_BITS'($urandom_range(IDX_SPARE_LAST, IDX_SPARE_FIRST)),
                  $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        longint t;
        longint pattern [16];
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= acmp_pkg::REG_THRESHOLD;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        src_idle_pct  = 11;
        sink_idle_pct = 60;
        thr_now = 32'((MAG_TOP + 5) / 10);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase * 3 / PHASES)
                0:
                begin
                    src_idle_pct  = 11;
                    sink_idle_pct = 60;
                end
                1:
                begin
                    src_idle_pct  = 60;
                    sink_idle_pct = 11;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                t = thr_now;
                pattern = '{0, 1, -1, t, -t, t + 1, -t - 1, t - 1, 1 - t, t / 2,
                            -(t / 2) - 1, MAG_TOP - 1, -MAG_TOP, 1 - MAG_TOP,
                            'h2AAAAA, -'h2AAAAB};
                for (int i = 0; i < 16; i++)
                    send_word(pattern[i][SAMPLE_BITS-1:0], i[0]);
            end
            else
            begin
                drain();
                case (phase)
                    1: write_all('1, '1, '1, '1, '1);
                    2: write_all('0, '0, '0, '0, '0);
                    3: write_all(32'd1 << 20, 32'd65536, 32'd4096, 32'd32768, 32'd16384);
                    default:
                        write_all($urandom(), $urandom(), $urandom(),
                                  $urandom_range(1) ? $urandom_range(32768) : $urandom(),
                                  $urandom_range(1) ? $urandom_range(32768) : $urandom());
                endcase
            end

            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(pick_sample(), $urandom_range(7, 0) == 0);
            s_tvalid <= 1'b0;
        end

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("audio_compander_core test passed");
        else
            $display("audio_compander_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
src/acmp_pkg.sv
src/acmp_front.sv
src/acmp_queue.sv
src/acmp_back.sv
src/audio_compander_core.sv
dv/acmp_checker.sv
dv/tb_top.sv
